FILE: rtl/irpd_pkg.sv
package irpd_pkg;

  localparam int TICK_W     = 16;
  localparam int TOL_W      = 7;
  localparam int PCT_W      = 8;
  localparam int PROD_W     = TICK_W + PCT_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int BYTE_W     = 8;
  localparam int BIT_IDX_W  = 3;
  localparam int BYTE_CNT_W = 7;
  localparam int BYTE_IDX_W = 6;
  localparam int EVENT_W    = 3;
  localparam int STATE_W    = 2;

  // bytes kept per frame before further bits are dropped (1 to 64)
  localparam int MAX_BYTES  = 64;

  typedef struct packed {
    logic action;
    logic carrier;
  } irpd_in_t;

  typedef struct packed {
    logic [EVENT_W-1:0]    event_res;
    logic                  byte_valid;
    logic [BYTE_W-1:0]     byte_value;
    logic [BYTE_IDX_W-1:0] byte_pos;
    logic                  overflow;
    logic [STATE_W-1:0]    rx_state;
  } irpd_out_t;

endpackage

FILE: rtl/irpd_stream_if.sv
interface irpd_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/ir_pulse_distance_receiver_top.sv
// IR pulse-distance receiver.
// samples (sink): one transaction per line sample tick (action 0, carrier =
//   line level) or a resume command (action 1) that clears the frame state.
// results (source): exactly one transaction per sample transaction, giving
//   the pair classification, a completed byte with its index, the overflow
//   flag and the receive phase after that tick.
// cfg_wr_en/cfg_index/cfg_wdata: register write port, index 0..7 selects
//   start/one/zero mark and space lengths, gap length and tolerance in
//   percent; other indexes are ignored. Write only while the block is idle.
// Throughput: one transaction per cycle while results.ready is high. Path: a
//   sample passes through the input register, then the result register.
//   Window bounds are nominal times percent, held in registers that update
//   in the cycle after the config registers.
// Reset: config registers take their default lengths, the receiver goes
//   idle and both pipeline registers empty; samples.ready is low during rst.
// Stall: while results.ready is low the result register holds, one more
//   transaction is taken into the input register, then samples.ready drops.
module ir_pulse_distance_receiver_top (
  input  logic                            clk,
  input  logic                            rst,
  irpd_stream_if.sink                     samples,
  irpd_stream_if.source                   results,
  input  logic                            cfg_wr_en,
  input  logic [irpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import irpd_pkg::*;

  typedef enum logic [STATE_W-1:0] {
    PH_IDLE  = 2'd0,
    PH_MARK  = 2'd1,
    PH_SPACE = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
  localparam logic [EVENT_W-1:0] EV_START     = 3'd1;
  localparam logic [EVENT_W-1:0] EV_ZERO      = 3'd2;
  localparam logic [EVENT_W-1:0] EV_ONE       = 3'd3;
  localparam logic [EVENT_W-1:0] EV_UNMATCHED = 3'd4;
  localparam logic [EVENT_W-1:0] EV_GAP       = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_START_MARK  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SPACE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MARK    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MARK   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAP         = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 4'd7;

  localparam int NOM_N = 6;

  // config registers; nominal order: start, one, zero, each mark then space
  logic [TICK_W-1:0] nominal [NOM_N];
  logic [TICK_W-1:0] gap_ticks;
  logic [TOL_W-1:0]  tolerance_pct;

  // window bounds scaled by 100
  logic [PCT_W-1:0]  lo_pct;
  logic [PCT_W-1:0]  hi_pct;
  logic [PROD_W-1:0] prod_lo [NOM_N];
  logic [PROD_W-1:0] prod_hi [NOM_N];

  logic              s1_valid;
  irpd_in_t          s1_data;
  logic              out_valid;
  irpd_out_t         out_data;
  logic              advance;
  logic              take;

  phase_t                phase, phase_next;
  logic                  started, started_next;
  logic [TICK_W-1:0]     mark_count, mark_next;
  logic [TICK_W-1:0]     space_count, space_next;
  logic [TICK_W-1:0]     space_sat;
  logic [BYTE_W-1:0]     shift_byte, shift_next;
  logic [BYTE_W-1:0]     shifted;
  logic [BIT_IDX_W-1:0]  bit_in_byte, bit_next;
  logic [BYTE_CNT_W-1:0] byte_count, bytes_next;

  logic [PROD_W-1:0]     mark100;
  logic [PROD_W-1:0]     space100;
  logic [NOM_N-1:0]      win_ok;
  logic                  pair_start, pair_one, pair_zero;
  logic                  bit_ok, bit_val;
  logic [EVENT_W-1:0]    ev_code;
  logic                  bvalid;
  logic [BYTE_W-1:0]     bvalue;
  logic [BYTE_IDX_W-1:0] bindex;
  logic                  ovf;

  function automatic logic [PROD_W-1:0] times100(input logic [TICK_W-1:0] v);
    logic [PROD_W-1:0] w;
    w = PROD_W'(v);
    times100 = (w << 6) + (w << 5) + (w << 2);
  endfunction

  // floor(lo/100) <= m  <=>  lo <= 100m + 99 ; m <= floor(hi/100) <=> 100m <= hi
  function automatic logic in_window(input logic [PROD_W-1:0] m100,
                                     input logic [PROD_W-1:0] lo,
                                     input logic [PROD_W-1:0] hi);
    in_window = (lo <= m100 + PROD_W'(99)) && (m100 <= hi);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal[0]    <= 16'd68;
      nominal[1]    <= 16'd35;
      nominal[2]    <= 16'd9;
      nominal[3]    <= 16'd26;
      nominal[4]    <= 16'd9;
      nominal[5]    <= 16'd9;
      gap_ticks     <= 16'd100;
      tolerance_pct <= 7'd25;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_START_MARK:  nominal[0]    <= cfg_wdata;
        REG_START_SPACE: nominal[1]    <= cfg_wdata;
        REG_ONE_MARK:    nominal[2]    <= cfg_wdata;
        REG_ONE_SPACE:   nominal[3]    <= cfg_wdata;
        REG_ZERO_MARK:   nominal[4]    <= cfg_wdata;
        REG_ZERO_SPACE:  nominal[5]    <= cfg_wdata;
        REG_GAP:         gap_ticks     <= cfg_wdata;
        REG_TOLERANCE:   tolerance_pct <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign lo_pct = (tolerance_pct >= 7'd100) ? '0 : PCT_W'(100) - PCT_W'(tolerance_pct);
  assign hi_pct = PCT_W'(100) + PCT_W'(tolerance_pct);

  for (genvar k = 0; k < NOM_N; k++) begin : g_bounds
    always_ff @(posedge clk) begin
      prod_lo[k] <= PROD_W'(nominal[k]) * PROD_W'(lo_pct);
      prod_hi[k] <= PROD_W'(nominal[k]) * PROD_W'(hi_pct);
    end
    if (k % 2 == 0) begin : g_mark
      assign win_ok[k] = in_window(mark100, prod_lo[k], prod_hi[k]);
    end else begin : g_space
      assign win_ok[k] = in_window(space100, prod_lo[k], prod_hi[k]);
    end
  end

  assign mark100    = times100(mark_count);
  assign space100   = times100(space_count);
  assign pair_start = win_ok[0] & win_ok[1];
  assign pair_one   = win_ok[2] & win_ok[3];
  assign pair_zero  = win_ok[4] & win_ok[5];
  assign space_sat  = (space_count == '1) ? space_count : space_count + 1'b1;

  assign advance       = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !rst && (!s1_valid || advance);
  assign take          = samples.valid && samples.ready;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  always_comb begin
    phase_next   = phase;
    started_next = started;
    mark_next    = mark_count;
    space_next   = space_count;
    shift_next   = shift_byte;
    bit_next     = bit_in_byte;
    bytes_next   = byte_count;
    ev_code      = EV_NONE;
    bit_ok       = 1'b0;
    bit_val      = 1'b0;
    shifted      = '0;
    bvalid       = 1'b0;
    bvalue       = '0;
    bindex       = '0;
    ovf          = 1'b0;
    if (s1_data.action) begin
      phase_next   = PH_IDLE;
      started_next = 1'b0;
      mark_next    = '0;
      space_next   = '0;
      shift_next   = '0;
      bit_next     = '0;
      bytes_next   = '0;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (s1_data.carrier) phase_next = PH_MARK;
        end
        PH_MARK: begin
          if (s1_data.carrier) begin
            if (mark_count != '1) mark_next = mark_count + 1'b1;
          end else begin
            phase_next = PH_SPACE;
          end
        end
        PH_SPACE: begin
          if (!s1_data.carrier) begin
            space_next = space_sat;
            if (space_sat > gap_ticks) begin
              phase_next = PH_STOP;
              ev_code    = EV_GAP;
            end
          end else begin
            if (pair_start) begin
              ev_code      = EV_START;
              started_next = 1'b1;
              shift_next   = '0;
              bit_next     = '0;
              bytes_next   = '0;
            end else if (started && pair_one) begin
              ev_code = EV_ONE;
              bit_ok  = 1'b1;
              bit_val = 1'b1;
            end else if (started && pair_zero) begin
              ev_code = EV_ZERO;
              bit_ok  = 1'b1;
            end else begin
              ev_code = EV_UNMATCHED;
            end
            if (bit_ok) begin
              shifted = {shift_byte[BYTE_W-2:0], bit_val};
              if (byte_count >= BYTE_CNT_W'(MAX_BYTES)) begin
                ovf = 1'b1;
              end else if (bit_in_byte == '1) begin
                bvalid     = 1'b1;
                bvalue     = shifted;
                bindex     = byte_count[BYTE_IDX_W-1:0];
                bytes_next = byte_count + 1'b1;
                bit_next   = '0;
                shift_next = '0;
              end else begin
                shift_next = shifted;
                bit_next   = bit_in_byte + 1'b1;
              end
            end
            if (ev_code != EV_UNMATCHED) begin
              mark_next  = '0;
              space_next = '0;
              phase_next = PH_MARK;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      phase       <= PH_IDLE;
      started     <= 1'b0;
      mark_count  <= '0;
      space_count <= '0;
      shift_byte  <= '0;
      bit_in_byte <= '0;
      byte_count  <= '0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
        s1_data  <= samples.data;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid           <= 1'b1;
        out_data.event_res  <= ev_code;
        out_data.byte_valid <= bvalid;
        out_data.byte_value <= bvalue;
        out_data.byte_pos   <= bindex;
        out_data.overflow   <= ovf;
        out_data.rx_state   <= phase_next;
        phase               <= phase_next;
        started             <= started_next;
        mark_count          <= mark_next;
        space_count         <= space_next;
        shift_byte          <= shift_next;
        bit_in_byte         <= bit_next;
        byte_count          <= bytes_next;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_ovf_no_byte: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.data.overflow && results.data.byte_valid))
    else $error("overflow reported together with a byte");

  a_byte_on_bit: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.byte_valid |->
      (results.data.event_res == EV_ONE || results.data.event_res == EV_ZERO))
    else $error("byte emitted without a data bit");

  a_gap_stops: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.event_res == EV_GAP |->
      results.data.rx_state == PH_STOP)
    else $error("gap event without stop state");

  a_resume_clears: assert property (@(posedge clk) disable iff (rst)
    advance && s1_data.action |=>
      phase == PH_IDLE && !started && byte_count == '0 && bit_in_byte == '0)
    else $error("resume left frame state behind");
`endif

endmodule
